// ----- rtl/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by spq_cell, sorted_priority_queue_top and the testbench.
package spq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_EXACT   = 2'd2,
    OP_GREATER = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic capture;  // latch compare flags against the incoming priority
    op_t  op;       // operation of the transfer being captured
    logic ins;      // apply insert shift
    logic rem;      // apply remove shift
  } spq_cmd_t;

endpackage

// ----- rtl/spq_cell.sv -----
// One slot of the sorted chain: holds one entry, compares it locally and
// shifts with its neighbors. Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
  parameter int PRIORITY_BITS = 8,
  parameter int DATA_BITS     = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  spq_cmd_t                 cmd,
  input  logic [PRIORITY_BITS-1:0] cmp_prio,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic [DATA_BITS-1:0]     new_data,
  input  logic                     left_valid,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic [DATA_BITS-1:0]     left_data,
  input  logic                     left_sel,
  input  logic                     right_valid,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  input  logic [DATA_BITS-1:0]     right_data,
  output logic                     valid,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic [DATA_BITS-1:0]     data,
  output logic                     sel,
  output logic                     take,
  output logic [DATA_BITS-1:0]     take_data
);

  logic cand;
  logic ge_v;
  logic gt_v;

  // empty slots act as priority "infinity"
  assign ge_v = !valid || (prio >= cmp_prio);
  assign gt_v = !valid || (prio > cmp_prio);

  // sel is monotonic along the chain, so the first set cell is the position
  assign take      = sel && !left_sel && cand;
  assign take_data = take ? data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      sel   <= 1'b0;
      cand  <= 1'b0;
    end else begin
      if (cmd.capture) begin
        case (cmd.op)
          OP_PUSH, OP_EXACT: sel <= ge_v;
          OP_GREATER:        sel <= gt_v;
          OP_POP:            sel <= 1'b1;
          default:           sel <= 1'b0;
        endcase
        cand <= valid && ((cmd.op == OP_EXACT) ? (prio == cmp_prio) : 1'b1);
      end
      if (cmd.ins) begin
        if (left_sel) begin
          valid <= left_valid;
          prio  <= left_prio;
          data  <= left_data;
        end else if (sel) begin
          valid <= 1'b1;
          prio  <= new_prio;
          data  <= new_data;
        end
      end else if (cmd.rem && sel) begin
        valid <= right_valid;
        prio  <= right_prio;
        data  <= right_data;
      end
    end
  end

endmodule

// ----- rtl/sorted_priority_queue_top.sv -----
// Sorted priority queue built as a chain of compare-and-shift cells.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Input channel (in_valid / in_stall) carries op, priority_req, payload.
//   Output channel (out_valid / out_stall) carries removed_data, status,
//   count; exactly one result per input transfer, in order.
//   Each cell holds one entry; the chain stays packed at the front and
//   sorted by ascending priority value, cell 0 being the head.
// Timing:
//   Cycle of the input transfer: every cell compares its priority against
//   priority_req and latches its position flag.
//   Shift phase: cells shift left or right in parallel and the result is
//   registered, together with out_valid, once the shift fires.
//   A new item is taken only after the shift of the last one is done.
// Stall:
//   in_stall is high during the shift phase. If the output register still
//   holds an untaken result, the shift waits until out_stall drops.
// Reset: rst (synchronous) empties the queue and drops out_valid; the
//   first item may follow in the next cycle.
module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int DATA_BITS     = 32,
  localparam int CNT_BITS     = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic [PRIORITY_BITS-1:0]    priority_req,
  input  logic signed [DATA_BITS-1:0] payload,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [DATA_BITS-1:0] removed_data,
  output logic [1:0]                  status,
  output logic [CNT_BITS-1:0]         count
);

  typedef enum logic {
    PH_IDLE,
    PH_SHIFT
  } phase_t;

  phase_t                   phase;
  op_t                      req_op;
  logic [PRIORITY_BITS-1:0] req_prio;
  logic [DATA_BITS-1:0]     req_data;
  logic [CNT_BITS-1:0]      entry_count;
  logic [CNT_BITS-1:0]      entry_count_next;

  logic     accept;
  logic     fire;
  logic     full;
  logic     hit;
  spq_cmd_t cmd;

  logic [CAPACITY:0]        valid_ext;
  logic [CAPACITY:0]        sel_ext;
  logic [PRIORITY_BITS-1:0] prio_ext [0:CAPACITY];
  logic [DATA_BITS-1:0]     data_ext [0:CAPACITY];
  logic [CAPACITY-1:0]      take_vec;
  logic [DATA_BITS-1:0]     take_data [0:CAPACITY-1];
  logic [DATA_BITS-1:0]     hit_data;
  status_t                  status_next;

  assign in_stall = (phase == PH_SHIFT);
  assign accept   = in_valid && !in_stall;
  assign fire     = (phase == PH_SHIFT) && (!out_valid || !out_stall);
  assign full     = (entry_count == CNT_BITS'(CAPACITY));
  assign hit      = |take_vec;

  assign cmd.capture = accept;
  assign cmd.op      = op_t'(op);
  assign cmd.ins     = fire && (req_op == OP_PUSH) && !full;
  assign cmd.rem     = fire && (req_op != OP_PUSH) && hit;

  // chain ends: nothing left of the head, an empty slot past the tail
  assign sel_ext[0]          = 1'b0;
  assign valid_ext[CAPACITY] = 1'b0;
  assign prio_ext[CAPACITY]  = '0;
  assign data_ext[CAPACITY]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     lv;
    logic [PRIORITY_BITS-1:0] lp;
    logic [DATA_BITS-1:0]     ld;

    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign lp = '0;
      assign ld = '0;
    end else begin : g_body
      assign lv = valid_ext[i-1];
      assign lp = prio_ext[i-1];
      assign ld = data_ext[i-1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS),
      .DATA_BITS    (DATA_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .cmp_prio   (priority_req),
      .new_prio   (req_prio),
      .new_data   (req_data),
      .left_valid (lv),
      .left_prio  (lp),
      .left_data  (ld),
      .left_sel   (sel_ext[i]),
      .right_valid(valid_ext[i+1]),
      .right_prio (prio_ext[i+1]),
      .right_data (data_ext[i+1]),
      .valid      (valid_ext[i]),
      .prio       (prio_ext[i]),
      .data       (data_ext[i]),
      .sel        (sel_ext[i+1]),
      .take       (take_vec[i]),
      .take_data  (take_data[i])
    );
  end

  // at most one cell takes, so an OR picks its data
  always_comb begin
    hit_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_data = hit_data | take_data[i];
    end
  end

  always_comb begin
    entry_count_next = entry_count;
    status_next      = ST_OK;
    case (req_op)
      OP_PUSH: begin
        if (full) status_next = ST_FULL;
        else      entry_count_next = entry_count + CNT_BITS'(1);
      end
      OP_POP: begin
        if (hit) entry_count_next = entry_count - CNT_BITS'(1);
        else     status_next = ST_EMPTY;
      end
      OP_EXACT, OP_GREATER: begin
        if (hit) entry_count_next = entry_count - CNT_BITS'(1);
        else     status_next = ST_NOMATCH;
      end
      default: status_next = ST_NOMATCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      out_valid   <= 1'b0;
      entry_count <= '0;
    end else begin
      if (accept) begin
        phase    <= PH_SHIFT;
        req_op   <= op_t'(op);
        req_prio <= priority_req;
        req_data <= payload;
      end
      if (fire) begin
        phase        <= PH_IDLE;
        out_valid    <= 1'b1;
        entry_count  <= entry_count_next;
        removed_data <= (req_op == OP_PUSH) ? '0 : hit_data;
        status       <= status_next;
        count        <= entry_count_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // occupancy bits track the count and stay packed at the head
  a_packed : assert property (@(posedge clk) disable iff (rst)
    ($countones(valid_ext) == entry_count) &&
    ((valid_ext & (valid_ext + 1'b1)) == '0))
    else $error("cell occupancy out of step with count");

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_BITS'(CAPACITY))
    else $error("count beyond capacity");

  a_single_take : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SHIFT) |-> $onehot0(take_vec))
    else $error("more than one cell selected for removal");

  a_result_after_fire : assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid && (count == entry_count))
    else $error("result not presented after shift");

  a_no_data_on_fail : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (removed_data == '0))
    else $error("data reported on failed operation");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for sorted_priority_queue_top: a queue-fed driver, a monitor and
// an in-bench priority queue predictor that produces the expected result of each transfer.
// Depends on spq_pkg and the RTL of sorted_priority_queue_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int CAP          = 16;
  localparam int PRIO_W       = 8;
  localparam int DATA_W       = 32;
  localparam int CNT_W        = 5;
  localparam int ITEM_TARGET  = 1950;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_START_A = 1500;
  localparam int HOLD_START_B = 5000;
  localparam int HOLD_LEN     = 150;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    op_t                     op;
    logic [PRIO_W-1:0]       prio;
    logic signed [DATA_W-1:0] data;
  } request_t;

  typedef struct {
    logic signed [DATA_W-1:0] removed;
    status_t                 status;
    logic [CNT_W-1:0]        count;
  } queue_result_t;

  typedef enum {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  op_t                      req_op = OP_PUSH;
  logic [PRIO_W-1:0]        req_prio = '0;
  logic signed [DATA_W-1:0] req_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] rsp_data;
  logic [1:0]               rsp_status;
  logic [CNT_W-1:0]         rsp_count;

  sorted_priority_queue_top #(
    .CAPACITY(CAP),
    .PRIORITY_BITS(PRIO_W),
    .DATA_BITS(DATA_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(req_op),
    .priority_req(req_prio),
    .payload(req_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .removed_data(rsp_data),
    .status(rsp_status),
    .count(rsp_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the queue contents, head at index 0
  logic [PRIO_W-1:0]        held_prio [CAP];
  logic signed [DATA_W-1:0] held_data [CAP];
  int                       held_count = 0;

  request_t      request_q[$];
  queue_result_t awaited_results[$];

  logic in_taken = 1'b0;
  int   cycle_count = 0;
  int   error_count = 0;
  int   result_count = 0;
  int   status_seen [4] = '{0, 0, 0, 0};
  int   deepest = 0;
  int   hold_left = 0;
  logic hold_off;

  assign hold_off = (hold_left != 0);

  function automatic logic signed [DATA_W-1:0] drop_at(int pos);
    logic signed [DATA_W-1:0] d;
    int i;
    d = held_data[pos];
    for (i = pos; i + 1 < held_count; i++) begin
      held_prio[i] = held_prio[i + 1];
      held_data[i] = held_data[i + 1];
    end
    held_count--;
    return d;
  endfunction

  function automatic queue_result_t predict_queue_op(request_t rq);
    queue_result_t r;
    int pos;
    int hit;
    int i;
    r.removed = '0;
    r.status  = ST_OK;
    case (rq.op)
      OP_PUSH: begin
        if (held_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          // ties go in front, so the newest of equal priorities leads
          pos = 0;
          while (pos < held_count && held_prio[pos] < rq.prio) pos++;
          for (i = held_count; i > pos; i--) begin
            held_prio[i] = held_prio[i - 1];
            held_data[i] = held_data[i - 1];
          end
          held_prio[pos] = rq.prio;
          held_data[pos] = rq.data;
          held_count++;
        end
      end
      OP_POP: begin
        if (held_count == 0) r.status = ST_EMPTY;
        else r.removed = drop_at(0);
      end
      default: begin
        hit = -1;
        for (i = 0; i < held_count; i++) begin
          if (hit < 0 && ((rq.op == OP_EXACT) ? (held_prio[i] == rq.prio)
                                              : (held_prio[i] > rq.prio))) begin
            hit = i;
          end
        end
        if (hit < 0) r.status = ST_NOMATCH;
        else r.removed = drop_at(hit);
      end
    endcase
    r.count = held_count[CNT_W-1:0];
    return r;
  endfunction

  function automatic void add_request(op_t o, logic [PRIO_W-1:0] p,
                                      logic signed [DATA_W-1:0] d);
    request_t rq;
    rq.op   = o;
    rq.prio = p;
    rq.data = d;
    request_q.push_back(rq);
  endfunction

  // Sender: bursts of transfers separated by random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_taken) void'(request_q.pop_front());
      if (in_valid && !in_taken) begin
        // stalled transfer holds its payload
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        req_op   <= request_q[0].op;
        req_prio <= request_q[0].prio;
        req_data <= request_q[0].data;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches between modes every so often
  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;
  int       rx_period = 2;
  int       rx_phase = 0;

  always @(negedge clk) begin
    logic s;
    if (rx_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      rx_left   = $urandom_range(20, 120);
      rx_period = $urandom_range(2, 7);
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      RX_FREE:     s = 1'b0;
      RX_RANDOM:   s = ($urandom_range(0, 99) < 30);
      RX_PERIODIC: s = ((rx_phase % rx_period) == 0);
      default:     s = ($urandom_range(0, 99) < 75);
    endcase
    out_stall <= hold_off || s;
  end

  // Long receiver hold-off so the queue backs up and stalls its input
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (cycle_count == HOLD_START_A || cycle_count == HOLD_START_B) hold_left <= HOLD_LEN;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, awaited_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    request_t      rq;
    queue_result_t want;
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        rq.op   = req_op;
        rq.prio = req_prio;
        rq.data = req_data;
        awaited_results.push_back(predict_queue_op(rq));
        if (held_count > deepest) deepest = held_count;
      end
      if (out_valid && !out_stall) begin
        result_count++;
        if (awaited_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("unexpected result: data %0d status %0d count %0d",
                     rsp_data, rsp_status, rsp_count);
        end else begin
          want = awaited_results.pop_front();
          status_seen[want.status]++;
          if (rsp_data !== want.removed || rsp_status !== want.status ||
              rsp_count !== want.count) begin
            error_count++;
            if (error_count <= REPORT_MAX)
              $display("result %0d: expected data %0d status %s count %0d, got data %0d status %0d count %0d",
                       result_count, want.removed, want.status.name(), want.count,
                       rsp_data, rsp_status, rsp_count);
          end
        end
      end
    end
  end

  initial begin
    int seg_len;
    int push_pct;
    int base;
    int k;
    bit narrow;
    op_t o;
    logic [PRIO_W-1:0] p;
    logic signed [DATA_W-1:0] d;

    // Directed: empty-queue cases, extremes, ties, each removal kind, full queue
    add_request(OP_POP, 8'd0, 32'sd0);
    add_request(OP_EXACT, 8'd100, 32'sd0);
    add_request(OP_PUSH, 8'd100, 32'sh7fffffff);
    add_request(OP_PUSH, 8'd100, -32'sd1);
    add_request(OP_PUSH, 8'd0, 32'sh80000000);
    add_request(OP_PUSH, 8'd255, 32'sd1);
    add_request(OP_EXACT, 8'd100, 32'sd0);
    add_request(OP_GREATER, 8'd100, 32'sd0);
    add_request(OP_POP, 8'd255, 32'sd0);
    add_request(OP_GREATER, 8'd255, 32'sd0);
    for (k = 0; k < CAP - 1; k++) add_request(OP_PUSH, 8'(k * 17), 32'(k));
    add_request(OP_PUSH, 8'd255, -32'sd1);

    // Random segments: the push rate swings the fill level between empty and full;
    // a narrow priority window makes ties and exact hits common
    while (request_q.size() < ITEM_TARGET) begin
      seg_len  = $urandom_range(40, 160);
      push_pct = $urandom_range(15, 85);
      narrow   = ($urandom_range(0, 2) != 0);
      base     = $urandom_range(0, 248);
      for (k = 0; k < seg_len; k++) begin
        if (narrow && $urandom_range(0, 99) >= 3) p = 8'(base + $urandom_range(0, 7));
        else p = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < push_pct) o = OP_PUSH;
        else o = op_t'($urandom_range(1, 3));
        case ($urandom_range(0, 15))
          0:       d = 32'sd0;
          1:       d = -32'sd1;
          2:       d = 32'sh80000000;
          3:       d = 32'sh7fffffff;
          default: d = $urandom;
        endcase
        add_request(o, p, d);
      end
    end

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results in %0d cycles: %0d ok, %0d no match, %0d empty, %0d full",
             result_count, cycle_count, status_seen[ST_OK], status_seen[ST_NOMATCH],
             status_seen[ST_EMPTY], status_seen[ST_FULL]);
    $display("deepest fill %0d of %0d entries, %0d mismatches", deepest, CAP, error_count);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
verif/testbench.sv
